// ===== hdl/asfp_pkg.sv =====
// ----------------------------------------------------------------------------
// asfp_pkg
// Shared types, codes and the CRC-8 helper for the ADC sample frame packer.
// ----------------------------------------------------------------------------
`default_nettype none

package asfp_pkg;

    localparam int SampleW = 12;
    localparam int ScaleW  = 16;
    localparam int ProdW   = SampleW + ScaleW;

    // input item kinds
    localparam logic OP_CMD    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // operating modes
    localparam logic [1:0] MODE_PAUSE = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_TRIG  = 2'd2;
    localparam logic [1:0] MODE_REC   = 2'd3;

    // register select (word address bit)
    localparam logic REG_FRAME_LEN  = 1'b0;
    localparam logic REG_FULL_SCALE = 1'b1;

    localparam logic [15:0] FRAME_LEN_RST  = 16'd512;
    localparam logic [15:0] FULL_SCALE_RST = 16'd3300;
    localparam logic [15:0] FRAME_LEN_MIN  = 16'd2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] SYNC_0   = 8'hAA;
    localparam logic [7:0] SYNC_1   = 8'h55;

    localparam int NumEnt = 6;

    typedef struct packed {
        logic       kind;
        logic       last;
        logic [7:0] data;
    } t_ent;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/adc_sample_frame_packer_crc8.sv =====
// ----------------------------------------------------------------------------
// adc_sample_frame_packer_crc8
// Frames scaled ADC samples into AA 55 / count / data / CRC-8 byte streams.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item reaches the result buffer after three register
// stages; its bytes are then offered from the buffer, entry 0 first.
// Throughput: one output word per cycle while m_axis_tready is high; words per
// item: 2 for a sample inside a frame, 6 opening, 3 closing, 1 for a command.
// Reset: synchronous, active low; mode pause, no frame open, CRC at 0xFF,
// frame_length 512, full_scale_mv 3300, pipeline and buffer empty.
`default_nettype none

module adc_sample_frame_packer_crc8
    import asfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] cmd_byte, [19:8] sample, rest 0
    input  wire logic        s_axis_tuser,   // [0] op
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [8] led_red,
                                             // [9] led_green, [10] led_blue, rest 0
    output logic             m_axis_tuser,   // [0] kind
    output logic             m_axis_tlast,   // last_of_frame
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [15:0] r_frame_len;
    logic [15:0] r_full_scale;

    // pipeline registers
    logic               r1_v, r2_v, r3_v;
    logic               r1_op, r2_op, r3_op;
    logic [7:0]         r1_cmd, r2_cmd, r3_cmd;
    logic [SampleW-1:0] r1_smp;
    logic [ProdW-1:0]   r2_p;
    logic [16:0]        r3_e;
    logic [13:0]        r3_r;

    // framing state
    logic [1:0]  r_mode, n_mode;
    logic        r_in_frame, n_in_frame;
    logic [15:0] r_sent, n_sent;
    logic [7:0]  r_crc, n_crc;

    // result buffer
    t_ent        r_ent [NumEnt];
    logic [2:0]  r_cnt;
    logic [2:0]  r_led;

    logic        rdy1, rdy2, rdy3;
    logic        s3_go, buf_load_ok, buf_load, buf_take;
    logic [2:0]  s3_n;
    t_ent        s3_ent [NumEnt];
    logic [2:0]  s3_led;

    logic [ProdW:0]   s2_sum;
    logic [16:0]      s2_e;
    logic [ProdW:0]   s2_r;

    logic [15:0] len_eff, cnt_base, cnt_nx;
    logic [16:0] q;
    logic [15:0] mv;
    logic [7:0]  crc_base, crc_nx;
    logic        open_f, close_f;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FULL_SCALE) ? {16'd0, r_full_scale}
                                                 : {16'd0, r_frame_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len  <= FRAME_LEN_RST;
            r_full_scale <= FULL_SCALE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_FRAME_LEN:  r_frame_len  <= pwdata[15:0];
                REG_FULL_SCALE: r_full_scale <= pwdata[15:0];
                default:        r_frame_len  <= r_frame_len;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------------
    assign buf_take    = (r_cnt != 3'd0) && m_axis_tready;
    assign buf_load_ok = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && m_axis_tready);
    assign s3_go       = r3_v && ((s3_n == 3'd0) || buf_load_ok);
    assign buf_load    = s3_go && (s3_n != 3'd0);
    assign rdy3        = !r3_v || s3_go;
    assign rdy2        = !r2_v || rdy3;
    assign rdy1        = !r1_v || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= s_axis_tvalid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    // stage 1 -> 2: scale product
    // stage 2 -> 3: quotient estimate by 1/4095 ~ (1 + 2^-12) / 2^12, and remainder
    assign s2_sum = {1'b0, r2_p} + {13'd0, r2_p[ProdW-1:12]};
    assign s2_e   = s2_sum[ProdW:12];
    assign s2_r   = {1'b0, r2_p} - (({12'd0, s2_e} << 12) - {12'd0, s2_e});

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r1_op  <= s_axis_tuser;
            r1_cmd <= s_axis_tdata[7:0];
            r1_smp <= s_axis_tdata[19:8];
        end
        if (rdy2 && r1_v) begin
            r2_op  <= r1_op;
            r2_cmd <= r1_cmd;
            r2_p   <= ProdW'(r1_smp * r_full_scale);
        end
        if (rdy3 && r2_v) begin
            r3_op  <= r2_op;
            r3_cmd <= r2_cmd;
            r3_e   <= s2_e;
            r3_r   <= s2_r[13:0];
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: framing decisions and result list
    // ------------------------------------------------------------------------
    always_comb begin
        len_eff  = (r_frame_len < FRAME_LEN_MIN) ? FRAME_LEN_MIN : r_frame_len;
        // estimate undershoots by at most two
        q = r3_e + ((r3_r >= 14'd8190) ? 17'd2 : ((r3_r >= 14'd4095) ? 17'd1 : 17'd0));
        mv = q[15:0];

        open_f   = !r_in_frame;
        cnt_base = open_f ? 16'd0 : r_sent;
        crc_base = open_f ? CRC_INIT : r_crc;
        cnt_nx   = cnt_base + 16'd1;
        crc_nx   = crc8_byte(crc8_byte(crc_base, mv[15:8]), mv[7:0]);
        close_f  = (cnt_nx >= len_eff);

        n_mode     = r_mode;
        n_in_frame = r_in_frame;
        n_sent     = r_sent;
        n_crc      = r_crc;
        s3_n       = 3'd0;
        for (int i = 0; i < NumEnt; i++) begin
            s3_ent[i] = '0;
        end

        if (r3_op == OP_CMD) begin
            if (r3_cmd <= {6'd0, MODE_REC}) n_mode = r3_cmd[1:0];
            s3_n = 3'd1;
        end else if (!r_in_frame && (r_mode == MODE_PAUSE)) begin
            s3_n = 3'd0;    // drop
        end else begin
            n_in_frame = !close_f;
            n_sent     = close_f ? 16'd0 : cnt_nx;
            n_crc      = close_f ? CRC_INIT : crc_nx;
            if (open_f) begin
                s3_ent[0] = '{kind: 1'b1, last: 1'b0, data: SYNC_0};
                s3_ent[1] = '{kind: 1'b1, last: 1'b0, data: SYNC_1};
                s3_ent[2] = '{kind: 1'b1, last: 1'b0, data: len_eff[15:8]};
                s3_ent[3] = '{kind: 1'b1, last: 1'b0, data: len_eff[7:0]};
                s3_ent[4] = '{kind: 1'b1, last: 1'b0, data: mv[15:8]};
                s3_ent[5] = '{kind: 1'b1, last: 1'b0, data: mv[7:0]};
                s3_n = 3'd6;
            end else begin
                s3_ent[0] = '{kind: 1'b1, last: 1'b0, data: mv[15:8]};
                s3_ent[1] = '{kind: 1'b1, last: 1'b0, data: mv[7:0]};
                s3_ent[2] = '{kind: 1'b1, last: 1'b1, data: crc_nx};
                s3_n = close_f ? 3'd3 : 3'd2;
            end
        end

        s3_led[0] = (n_mode == MODE_TRIG) || (n_mode == MODE_REC);
        s3_led[1] = (n_mode == MODE_RUN)  || (n_mode == MODE_TRIG);
        s3_led[2] = (n_mode == MODE_PAUSE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PAUSE;
            r_in_frame <= 1'b0;
            r_sent     <= 16'd0;
            r_crc      <= CRC_INIT;
        end else if (s3_go) begin
            r_mode     <= n_mode;
            r_in_frame <= n_in_frame;
            r_sent     <= n_sent;
            r_crc      <= n_crc;
        end
    end

    // ------------------------------------------------------------------------
    // result buffer: present entry 0, shift down on each word taken
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (buf_load) begin
            r_cnt <= s3_n;
        end else if (buf_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_load) begin
            r_ent <= s3_ent;
            r_led <= s3_led;
        end else if (buf_take) begin
            for (int i = 0; i < NumEnt - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
            r_ent[NumEnt-1] <= '0;
        end
    end

    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tuser  = r_ent[0].kind;
    assign m_axis_tlast  = r_ent[0].last;
    assign m_axis_tdata  = {5'd0, r_led[2], r_led[1], r_led[0], r_ent[0].data};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd6)
        else $error("result buffer count out of range");

    a_last_is_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("frame end marked on a status word");

    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_sent == 16'd0 && r_crc == CRC_INIT))
        else $error("framing state not cleared outside a frame");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_load |-> (r_cnt == 3'd0 || (r_cnt == 3'd1 && buf_take)))
        else $error("result buffer overwritten while holding words");

endmodule

`default_nettype wire
